// ===== rtl/core/rcg_pkg.sv =====
// Shared types and constants for the rolling cost grid store.
`timescale 1ns / 1ps
package rcg_pkg;
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(CELLS);

  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_RECT  = 3'd3;
  localparam logic [2:0] CMD_SHIFT = 3'd4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FILL   = 2'd2;

  typedef enum logic [2:0] {OP_NOP, OP_READ, OP_WRITE, OP_FILL, OP_SHIFT} op_t;

  typedef struct packed {
    op_t               op;
    logic              oor;
    logic              clr;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] last;
    logic [7:0]        x0;
    logic [7:0]        x1;
    logic [7:0]        y0;
    logic [7:0]        y1;
    logic [7:0]        w;
    logic [7:0]        h;
    logic [7:0]        wcost;
    logic [7:0]        fill;
    logic [7:0]        dx;
    logic [7:0]        dy;
    logic [ADDR_W:0]   off;
    logic              desc;
  } cmd_t;
endpackage

// ===== rtl/core/rcg_in_if.sv =====
// Command channel interface.
`timescale 1ns / 1ps
interface rcg_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [6:0]         cell_x;
  logic [6:0]         cell_y;
  logic [7:0]         end_x;
  logic [7:0]         end_y;
  logic [7:0]         write_cost;
  logic signed [10:0] shift_x;
  logic signed [10:0] shift_y;
  modport source (output valid, command, cell_x, cell_y, end_x, end_y, write_cost,
                  shift_x, shift_y, input ready);
  modport sink (input valid, command, cell_x, cell_y, end_x, end_y, write_cost,
                shift_x, shift_y, output ready);
endinterface

// ===== rtl/core/rcg_out_if.sv =====
// Result channel interface.
`timescale 1ns / 1ps
interface rcg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_cost;
  logic       out_of_range;
  logic       cleared_all;
  modport source (output valid, read_cost, out_of_range, cleared_all, input ready);
  modport sink (input valid, read_cost, out_of_range, cleared_all, output ready);
endinterface

// ===== rtl/core/rcg_front.sv =====
// Front end: configuration registers, command decode and address products.
`timescale 1ns / 1ps
module rcg_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  rcg_in_if.sink        items,
  input  logic          q_full,
  input  logic          init_done,
  output logic          push,
  output rcg_pkg::cmd_t entry
);
  logic [7:0] grid_width, grid_height, fill_value;
  logic [7:0] w, h;
  logic [10:0] ax, ay;
  logic signed [11:0] mul_a;
  logic signed [20:0] prod;
  logic [15:0] cells;
  logic [20:0] off_sum;
  logic big, zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 8'd128;
      grid_height <= 8'd128;
      fill_value  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        rcg_pkg::REG_WIDTH:  grid_width  <= cfg_data;
        rcg_pkg::REG_HEIGHT: grid_height <= cfg_data;
        rcg_pkg::REG_FILL:   fill_value  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w = grid_width;
    if (grid_width == 8'd0) w = 8'd1;
    else if (grid_width > 8'(rcg_pkg::MAX_WIDTH)) w = 8'(rcg_pkg::MAX_WIDTH);
    h = grid_height;
    if (grid_height == 8'd0) h = 8'd1;
    else if (grid_height > 8'(rcg_pkg::MAX_HEIGHT)) h = 8'(rcg_pkg::MAX_HEIGHT);
  end

  assign items.ready = ~q_full & init_done;
  assign push        = items.valid & items.ready;

  assign ax = items.shift_x[10] ? 11'(-items.shift_x) : items.shift_x;
  assign ay = items.shift_y[10] ? 11'(-items.shift_y) : items.shift_y;
  assign big  = (ax >= {3'b0, w}) || (ay >= {3'b0, h});
  assign zero = (items.shift_x == 11'sd0) && (items.shift_y == 11'sd0);

  assign mul_a = (items.command == rcg_pkg::CMD_SHIFT) ? 12'(items.shift_y)
                                                       : {5'b0, items.cell_y};
  assign prod    = mul_a * $signed({1'b0, w});
  assign cells   = {8'b0, h} * {8'b0, w};
  assign off_sum = prod + 21'(items.shift_x);

  always_comb begin
    entry       = '0;
    entry.op    = rcg_pkg::OP_NOP;
    entry.addr  = rcg_pkg::ADDR_W'(prod[rcg_pkg::ADDR_W-1:0]
                  + rcg_pkg::ADDR_W'(items.cell_x));
    entry.base  = prod[rcg_pkg::ADDR_W-1:0];
    entry.last  = rcg_pkg::ADDR_W'(cells - 16'd1);
    entry.x0    = {1'b0, items.cell_x};
    entry.x1    = items.end_x;
    entry.y0    = {1'b0, items.cell_y};
    entry.y1    = items.end_y;
    entry.w     = w;
    entry.h     = h;
    entry.wcost = items.write_cost;
    entry.fill  = fill_value;
    entry.dx    = items.shift_x[7:0];
    entry.dy    = items.shift_y[7:0];
    entry.off   = off_sum[rcg_pkg::ADDR_W:0];
    entry.desc  = items.shift_y[10] || ((items.shift_y == 11'sd0) && items.shift_x[10]);
    case (items.command)
      rcg_pkg::CMD_READ, rcg_pkg::CMD_WRITE: begin
        entry.oor = ({1'b0, items.cell_x} >= w) || ({1'b0, items.cell_y} >= h);
        if (!entry.oor)
          entry.op = (items.command == rcg_pkg::CMD_READ) ? rcg_pkg::OP_READ
                                                          : rcg_pkg::OP_WRITE;
      end
      rcg_pkg::CMD_CLEAR: begin
        entry.clr = 1'b1;
        entry.op  = rcg_pkg::OP_FILL;
      end
      rcg_pkg::CMD_RECT: begin
        entry.oor = ({1'b0, items.cell_x} > items.end_x) ||
                    ({1'b0, items.cell_y} > items.end_y) ||
                    (items.end_x > w) || (items.end_y > h);
        if (!entry.oor && ({1'b0, items.cell_x} != items.end_x) &&
            ({1'b0, items.cell_y} != items.end_y))
          entry.op = rcg_pkg::OP_FILL;
      end
      rcg_pkg::CMD_SHIFT: begin
        if (!zero) begin
          if (big) begin
            entry.clr = 1'b1;
            entry.op  = rcg_pkg::OP_FILL;
          end else begin
            entry.op = rcg_pkg::OP_SHIFT;
          end
        end
      end
      default: ;
    endcase
    if (entry.clr) begin
      entry.x0   = 8'd0;
      entry.y0   = 8'd0;
      entry.x1   = w;
      entry.y1   = h;
      entry.base = '0;
    end
  end
endmodule

// ===== rtl/core/rcg_queue.sv =====
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps
module rcg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rcg_pkg::cmd_t din,
  input  logic          pop,
  output logic          valid,
  output logic          full,
  output rcg_pkg::cmd_t head
);
  rcg_pkg::cmd_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign valid = count != 2'd0;
  assign full  = count == 2'd2;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end
endmodule

// ===== rtl/core/rcg_back.sv =====
// Back end: cost memory, cell sweeps, shift copy and result register.
`timescale 1ns / 1ps
module rcg_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  rcg_pkg::cmd_t q_head,
  output logic          pop,
  output logic          init_done,
  rcg_out_if.source     results
);
  typedef enum logic [2:0] {S_INIT, S_IDLE, S_RD, S_FILL, S_SHIFT, S_DRAIN, S_DONE} state_t;

  state_t state;
  rcg_pkg::cmd_t cur;
  logic [7:0] mem [rcg_pkg::CELLS];
  logic [7:0] mem_q;
  logic mem_we;
  logic [rcg_pkg::ADDR_W-1:0] waddr, raddr, cnt, base, d;
  logic [7:0] wdata, r, c;
  logic p_valid, p_inside;
  logic [rcg_pkg::ADDR_W-1:0] p_dest;
  logic [7:0] res_rd;
  logic res_oor, res_clr;
  logic [9:0] sr, sc;
  logic [rcg_pkg::ADDR_W:0] src_sum;
  logic in_grid, last, res_load;

  assign init_done = state != S_INIT;
  assign pop       = (state == S_IDLE) && q_valid;
  assign res_load  = (state == S_DONE) && (!results.valid || results.ready);

  assign sr      = {2'b0, r} + {{2{cur.dy[7]}}, cur.dy};
  assign sc      = {2'b0, c} + {{2{cur.dx[7]}}, cur.dx};
  assign in_grid = !sr[9] && (sr[8:0] < {1'b0, cur.h}) && !sc[9] && (sc[8:0] < {1'b0, cur.w});
  assign src_sum = {1'b0, d} + cur.off;
  assign last    = cur.desc ? (r == 8'd0 && c == 8'd0)
                            : (r == 8'(cur.h - 8'd1) && c == 8'(cur.w - 8'd1));

  always_comb begin
    mem_we = 1'b0;
    waddr  = '0;
    wdata  = '0;
    raddr  = cur.addr;
    case (state)
      S_INIT: begin
        mem_we = 1'b1;
        waddr  = cnt;
      end
      S_IDLE: begin
        raddr = q_head.addr;
        if (q_valid && q_head.op == rcg_pkg::OP_WRITE) begin
          mem_we = 1'b1;
          waddr  = q_head.addr;
          wdata  = q_head.wcost;
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        waddr  = rcg_pkg::ADDR_W'(base + rcg_pkg::ADDR_W'(c));
        wdata  = cur.fill;
      end
      S_SHIFT: raddr = src_sum[rcg_pkg::ADDR_W-1:0];
      default: ;
    endcase
    if (p_valid) begin
      mem_we = 1'b1;
      waddr  = p_dest;
      wdata  = p_inside ? mem_q : cur.fill;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      cnt           <= '0;
      p_valid       <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (res_load) results.valid <= 1'b1;
      else if (results.valid && results.ready) results.valid <= 1'b0;
      case (state)
        S_INIT: begin
          cnt <= rcg_pkg::ADDR_W'(cnt + 1'b1);
          if (&cnt) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur     <= q_head;
            res_rd  <= 8'd0;
            res_oor <= q_head.oor;
            res_clr <= q_head.clr;
            case (q_head.op)
              rcg_pkg::OP_READ: state <= S_RD;
              rcg_pkg::OP_FILL: begin
                r     <= q_head.y0;
                c     <= q_head.x0;
                base  <= q_head.base;
                state <= S_FILL;
              end
              rcg_pkg::OP_SHIFT: begin
                r     <= q_head.desc ? 8'(q_head.h - 8'd1) : 8'd0;
                c     <= q_head.desc ? 8'(q_head.w - 8'd1) : 8'd0;
                d     <= q_head.desc ? q_head.last : '0;
                state <= S_SHIFT;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RD: begin
          res_rd <= mem_q;
          state  <= S_DONE;
        end
        S_FILL: begin
          if (c == 8'(cur.x1 - 8'd1)) begin
            c <= cur.x0;
            if (r == 8'(cur.y1 - 8'd1)) state <= S_DONE;
            else begin
              r    <= 8'(r + 8'd1);
              base <= rcg_pkg::ADDR_W'(base + rcg_pkg::ADDR_W'(cur.w));
            end
          end else begin
            c <= 8'(c + 8'd1);
          end
        end
        S_SHIFT: begin
          p_valid  <= 1'b1;
          p_dest   <= d;
          p_inside <= in_grid;
          if (last) state <= S_DRAIN;
          else if (cur.desc) begin
            d <= rcg_pkg::ADDR_W'(d - 1'b1);
            if (c == 8'd0) begin
              c <= 8'(cur.w - 8'd1);
              r <= 8'(r - 8'd1);
            end else c <= 8'(c - 8'd1);
          end else begin
            d <= rcg_pkg::ADDR_W'(d + 1'b1);
            if (c == 8'(cur.w - 8'd1)) begin
              c <= 8'd0;
              r <= 8'(r + 8'd1);
            end else c <= 8'(c + 8'd1);
          end
        end
        S_DRAIN: begin
          p_valid <= 1'b0;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            results.read_cost    <= res_rd;
            results.out_of_range <= res_oor;
            results.cleared_all  <= res_clr;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/rolling_cost_grid_store_top.sv =====
// Top level of the rolling cost grid store.
//  channel  | dir | handshake     | payload
//  items    | in  | valid / ready | command, cell, rectangle, cost, shift
//  results  | out | valid / ready | read_cost, out_of_range, cleared_all
//  cfg      | in  | cfg_we        | cfg_index, cfg_data
// Reads, writes, rectangle fills, clears and shifts all share the single
// port pair of the cost memory.
// After reset a clearing pass zeroes every cell of the memory; items wait.
// A two-entry queue lets commands transfer in while a result is held.
`timescale 1ns / 1ps
module rolling_cost_grid_store_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  rcg_in_if.sink     items,
  rcg_out_if.source  results
);
  rcg_pkg::cmd_t entry, head;
  logic push, pop, q_valid, q_full, init_done;

  rcg_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .items,
    .q_full, .init_done, .push, .entry
  );

  rcg_queue u_queue (
    .clk, .rst, .push, .din(entry), .pop, .valid(q_valid), .full(q_full), .head
  );

  rcg_back u_back (
    .clk, .rst, .q_valid, .q_head(head), .pop, .init_done, .results
  );
endmodule

// ===== rtl/core/rcg_checker.sv =====
// Port checks for the rolling cost grid store, bound to the top level.
`timescale 1ns / 1ps
module rcg_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_cost,
  input logic       out_of_range,
  input logic       cleared_all
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_init: assert property (@(posedge clk) rst |=> !in_ready && !out_valid)
    else $error("activity during clearing pass");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_of_range && cleared_all)) else $error("flags both set");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_of_range || cleared_all) |-> read_cost == 8'd0)
    else $error("cost on non-read");
endmodule

bind rolling_cost_grid_store_top rcg_checker u_chk (
  .clk, .rst, .in_ready(items.ready), .out_valid(results.valid),
  .out_ready(results.ready), .read_cost(results.read_cost),
  .out_of_range(results.out_of_range), .cleared_all(results.cleared_all)
);
